### rtl/complex_arith_unit_top_assert.svh
// Assertion macros shared by the checker of complex_arith_unit_top.
// Expects clk_i and rst_ni in scope where a macro is used.
`ifndef COMPLEX_ARITH_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cau check failed");

// Implication after a fixed number of cycles, disabled in reset.
`define CAU_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("cau check failed");

`endif

### rtl/cau_pkg.sv
// Package for the complex arithmetic unit: opcodes, status codes, pipeline constants.
// No dependencies.
`default_nettype none
package cau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_EQ   = 3'd4,
    CMD_MAG  = 3'd5,
    CMD_CONJ = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  localparam int CAU_FRAC_BITS = 8;
  // quotient / root bits, one per pipeline stage
  localparam int CAU_QBITS = 16;
  // accept edge to the edge at which the result is sampled
  localparam int CAU_LATENCY = CAU_QBITS + 5;

endpackage
`default_nettype wire

### rtl/cau_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Standalone; used by complex_arith_unit_top.
`default_nettype none
module cau_divider #(
  parameter int NW = 41,
  parameter int DW = 32,
  parameter int QW = 16
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [QW-1:0] quo_o,
  output logic               ovf_o
);
  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          ovf_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic          ovf_in;
    logic [CW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      // quotient would not fit in QW bits
      assign ovf_in = CW'(num_i) >= (CW'(den_i) << QW);
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    assign trial = CW'(den_in) << B;
    assign take  = CW'(rem_in) >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? NW'(CW'(rem_in) - trial) : rem_in;
      quo_q[k] <= quo_in | (take ? (QW'(1) << B) : QW'(0));
      den_q[k] <= den_in;
      ovf_q[k] <= ovf_in;
    end
  end

  assign quo_o = quo_q[QW-1];
  assign ovf_o = ovf_q[QW-1];

endmodule
`default_nettype wire

### rtl/cau_sqrt.sv
// Pipelined integer square root of a 32-bit value, two radicand bits per stage.
// Depends on cau_pkg.
`default_nettype none
module cau_sqrt
  import cau_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic [31:0] sq_i,
  output logic      [15:0] root_o,
  output logic      [31:0] rem_o
);
  logic [31:0] x_q [CAU_QBITS];
  logic [31:0] r_q [CAU_QBITS];

  for (genvar k = 0; k < CAU_QBITS; k++) begin : g_stage
    localparam logic [31:0] BIT = 32'(1) << (30 - 2 * k);
    logic [31:0] x_in;
    logic [31:0] r_in;
    logic [32:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign x_in = sq_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = {1'b0, r_in} + {1'b0, BIT};
    assign take  = {1'b0, x_in} >= trial;

    always_ff @(posedge clk_i) begin
      x_q[k] <= take ? 32'({1'b0, x_in} - trial) : x_in;
      r_q[k] <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
    end
  end

  assign root_o = r_q[CAU_QBITS-1][15:0];
  assign rem_o  = x_q[CAU_QBITS-1];

endmodule
`default_nettype wire

### rtl/complex_arith_unit_top.sv
// Complex-number ALU in signed fixed point: top level with operand, product and sum stages.
// Depends on cau_pkg, cau_divider, cau_sqrt.
//
// Usage:
//  - Input channel: drive command_i and the four operand parts and raise start;
//    the item is taken at a rising edge where start is high and busy is low.
//    busy stays low: a new item can be taken in every cycle.
//  - Result channel: res_valid_o is high for exactly one cycle per item, with
//    res_re_o, res_im_o, equal_o and status_o valid in that cycle. The receiver
//    cannot stall, so there is no backpressure and nothing to hold.
//  - Ordering: every command passes through the same pipeline, so results
//    leave in order.
//  - Throughput: one item per cycle. The fixed depth comes from the divider and
//    square root, which resolve one quotient or root bit per stage (16 stages),
//    behind operand, product, sum and preparation stages and one output stage.
//  - Reset (rst_ni low, asynchronous) clears every valid bit; items in flight
//    are dropped and no result appears until a new item is taken.
//  - Status: ok, divide by zero (results zero) or saturated (either part clamped).
`default_nettype none
module complex_arith_unit_top
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         command_i,
  input  wire logic signed [15:0] a_re_i,
  input  wire logic signed [15:0] a_im_i,
  input  wire logic signed [15:0] b_re_i,
  input  wire logic signed [15:0] b_im_i,
  output logic                    res_valid_o,
  output logic signed [15:0]      res_re_o,
  output logic signed [15:0]      res_im_o,
  output logic                    equal_o,
  output logic [1:0]              status_o
);
  // scaled numerator magnitude plus half the divisor
  localparam int NW = 33 + FRAC_BITS;
  localparam logic signed [34:0] HALF = (35'sd1 <<< FRAC_BITS) >>> 1;

  typedef struct packed {
    logic signed [15:0] v;
    logic               sat;
  } sat_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               eq;
    logic [1:0]         status;
    logic               neg_re;
    logic               neg_im;
    logic               div0;
  } side_t;

  function automatic sat_t sat16(input logic signed [34:0] v);
    sat_t s;
    if (v > 35'sd32767) begin
      s.v = 16'sh7fff; s.sat = 1'b1;
    end else if (v < -35'sd32768) begin
      s.v = -16'sh8000; s.sat = 1'b1;
    end else begin
      s.v = 16'(v); s.sat = 1'b0;
    end
    return s;
  endfunction

  // signed quotient from magnitude, overflow flag and sign
  function automatic sat_t div_fix(input logic [15:0] q, input logic ovf, input logic neg);
    logic signed [34:0] v;
    v = neg ? -35'($unsigned(q)) : 35'($unsigned(q));
    if (ovf) v = neg ? -35'sd65536 : 35'sd65536;
    return sat16(v);
  endfunction

  assign busy = 1'b0;

  // ---- stage 0: operand registers
  logic               v0_q;
  logic [2:0]         cmd0_q;
  logic signed [15:0] a0_q, b0_q, c0_q, d0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd0_q <= command_i;
    a0_q   <= a_re_i;
    b0_q   <= a_im_i;
    c0_q   <= b_re_i;
    d0_q   <= b_im_i;
  end

  // ---- stage 1: products
  logic               v1_q;
  logic [2:0]         cmd1_q;
  logic signed [15:0] a1_q, b1_q, c1_q, d1_q;
  logic signed [31:0] p_ac_q, p_bd_q, p_ad_q, p_bc_q, p_cc_q, p_dd_q, p_aa_q, p_bb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= cmd0_q;
    a1_q   <= a0_q;
    b1_q   <= b0_q;
    c1_q   <= c0_q;
    d1_q   <= d0_q;
    p_ac_q <= a0_q * c0_q;
    p_bd_q <= b0_q * d0_q;
    p_ad_q <= a0_q * d0_q;
    p_bc_q <= b0_q * c0_q;
    p_cc_q <= c0_q * c0_q;
    p_dd_q <= d0_q * d0_q;
    p_aa_q <= a0_q * a0_q;
    p_bb_q <= b0_q * b0_q;
  end

  // ---- stage 2: sums, raw add/sub/conjugate, equality
  logic               v2_q;
  logic [2:0]         cmd2_q;
  logic signed [32:0] mre_q, mim_q, nre_q, nim_q;
  logic [31:0]        den_q, sq_q;
  logic signed [16:0] raw_re_d, raw_im_d, raw_re_q, raw_im_q;
  logic               eq2_q;

  always_comb begin
    case (cmd1_q)
      CMD_ADD: begin
        raw_re_d = 17'(a1_q) + 17'(c1_q);
        raw_im_d = 17'(b1_q) + 17'(d1_q);
      end
      CMD_SUB: begin
        raw_re_d = 17'(a1_q) - 17'(c1_q);
        raw_im_d = 17'(b1_q) - 17'(d1_q);
      end
      CMD_CONJ: begin
        raw_re_d = 17'(a1_q);
        raw_im_d = -17'(b1_q);
      end
      default: begin
        raw_re_d = '0;
        raw_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q   <= cmd1_q;
    mre_q    <= 33'(p_ac_q) - 33'(p_bd_q);
    mim_q    <= 33'(p_ad_q) + 33'(p_bc_q);
    nre_q    <= 33'(p_ac_q) + 33'(p_bd_q);
    nim_q    <= 33'(p_bc_q) - 33'(p_ad_q);
    den_q    <= 32'($unsigned(p_cc_q)) + 32'($unsigned(p_dd_q));
    sq_q     <= 32'($unsigned(p_aa_q)) + 32'($unsigned(p_bb_q));
    raw_re_q <= raw_re_d;
    raw_im_q <= raw_im_d;
    eq2_q    <= (a1_q == c1_q) && (b1_q == d1_q);
  end

  // ---- stage 3: rounding and saturation of simple ops, divider preparation
  logic          v3_q;
  side_t         side3_d, side3_q;
  logic [31:0]   un_re, un_im;
  logic [NW-1:0] num_re_d, num_im_d, num_re_q, num_im_q;
  logic [31:0]   den3_q, sq3_q;
  sat_t          s_re, s_im;

  always_comb begin
    un_re    = nre_q[32] ? 32'(-nre_q) : nre_q[31:0];
    un_im    = nim_q[32] ? 32'(-nim_q) : nim_q[31:0];
    num_re_d = (NW'(un_re) << FRAC_BITS) + NW'(den_q >> 1);
    num_im_d = (NW'(un_im) << FRAC_BITS) + NW'(den_q >> 1);

    s_re = '0;
    s_im = '0;
    case (cmd2_q)
      CMD_ADD, CMD_SUB, CMD_CONJ: begin
        s_re = sat16(35'(raw_re_q));
        s_im = sat16(35'(raw_im_q));
      end
      CMD_MUL: begin
        s_re = sat16((35'(mre_q) + HALF) >>> FRAC_BITS);
        s_im = sat16((35'(mim_q) + HALF) >>> FRAC_BITS);
      end
      default: ;
    endcase

    side3_d.cmd    = cmd2_q;
    side3_d.re     = s_re.v;
    side3_d.im     = s_im.v;
    side3_d.eq     = (cmd2_q == CMD_EQ) && eq2_q;
    side3_d.status = (s_re.sat || s_im.sat) ? ST_SAT : ST_OK;
    side3_d.neg_re = nre_q[32];
    side3_d.neg_im = nim_q[32];
    side3_d.div0   = den_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q  <= side3_d;
    num_re_q <= num_re_d;
    num_im_q <= num_im_d;
    den3_q   <= den_q;
    sq3_q    <= sq_q;
  end

  // ---- bit-serial stages: two dividers and the square root in parallel lanes
  logic [15:0] q_re, q_im, root;
  logic        ovf_re, ovf_im;
  logic [31:0] rem;

  cau_divider #(.NW(NW), .DW(32), .QW(CAU_QBITS)) u_div_re (
    .clk_i (clk_i),
    .num_i (num_re_q),
    .den_i (den3_q),
    .quo_o (q_re),
    .ovf_o (ovf_re)
  );

  cau_divider #(.NW(NW), .DW(32), .QW(CAU_QBITS)) u_div_im (
    .clk_i (clk_i),
    .num_i (num_im_q),
    .den_i (den3_q),
    .quo_o (q_im),
    .ovf_o (ovf_im)
  );

  cau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .sq_i   (sq3_q),
    .root_o (root),
    .rem_o  (rem)
  );

  // side information and valid bits ride alongside the lanes
  side_t side_dl_q [CAU_QBITS];
  logic  vld_dl_q  [CAU_QBITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAU_QBITS; i++) vld_dl_q[i] <= 1'b0;
    end else begin
      vld_dl_q[0] <= v3_q;
      for (int i = 1; i < CAU_QBITS; i++) vld_dl_q[i] <= vld_dl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_dl_q[0] <= side3_q;
    for (int i = 1; i < CAU_QBITS; i++) side_dl_q[i] <= side_dl_q[i-1];
  end

  // ---- output stage: final select
  side_t       fin;
  sat_t        d_re, d_im, m_s;
  logic [16:0] mag;
  logic        res_valid_q, equal_q;
  logic signed [15:0] res_re_d, res_im_d, res_re_q, res_im_q;
  logic [1:0]  status_d, status_q;

  always_comb begin
    fin  = side_dl_q[CAU_QBITS-1];
    d_re = div_fix(q_re, ovf_re, fin.neg_re);
    d_im = div_fix(q_im, ovf_im, fin.neg_im);
    // round to nearest: remainder s - r*r above r rounds up
    mag  = {1'b0, root} + 17'(rem > 32'(root));
    m_s  = sat16(35'($unsigned(mag)));

    res_re_d = fin.re;
    res_im_d = fin.im;
    status_d = fin.status;
    case (fin.cmd)
      CMD_DIV: begin
        if (fin.div0) begin
          res_re_d = '0;
          res_im_d = '0;
          status_d = ST_DIV0;
        end else begin
          res_re_d = d_re.v;
          res_im_d = d_im.v;
          status_d = (d_re.sat || d_im.sat) ? ST_SAT : ST_OK;
        end
      end
      CMD_MAG: begin
        res_re_d = m_s.v;
        res_im_d = '0;
        status_d = m_s.sat ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= vld_dl_q[CAU_QBITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    equal_q  <= fin.eq;
    status_q <= status_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign equal_o     = equal_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

### rtl/cau_checker.sv
// Port-level checker for complex_arith_unit_top, bound to it below.
// Depends on cau_pkg and complex_arith_unit_top_assert.svh.
`default_nettype none
`include "complex_arith_unit_top_assert.svh"
module cau_checker
  import cau_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               res_valid_o,
  input wire logic signed [15:0] res_re_o,
  input wire logic signed [15:0] res_im_o,
  input wire logic               equal_o,
  input wire logic [1:0]         status_o
);
  // every taken item yields its result after the fixed latency
  `CAU_ASSERT_DLY(a_latency, start && !busy, CAU_LATENCY, res_valid_o)
  // divide by zero returns a zero result
  `CAU_ASSERT_IMP(a_div0_zero, res_valid_o && (status_o == ST_DIV0), (res_re_o == 16'sd0) && (res_im_o == 16'sd0))
  // a match comes only from the equal test, whose parts are zero
  `CAU_ASSERT_IMP(a_eq_zero, res_valid_o && equal_o, (res_re_o == 16'sd0) && (res_im_o == 16'sd0) && (status_o == ST_OK))
  // status code three is never produced
  `CAU_ASSERT_IMP(a_status_code, res_valid_o, (status_o == ST_OK) || (status_o == ST_DIV0) || (status_o == ST_SAT))

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);
`default_nettype wire
